### rtl/core/cbst_pkg.sv
// Package with the constants and codes of the channel bimap snoop table.
package cbst_pkg;

    localparam int CHANNEL_COUNT = 24;
    localparam int CHAN_W        = $clog2(CHANNEL_COUNT);
    localparam int ANSWER_W      = 5;
    localparam int DATA_W        = 32;
    localparam int QUERY_W       = 8;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_P2L   = 2'd1;
    localparam logic [1:0] MODE_L2P   = 2'd2;

    localparam logic [1:0] CFG_WINDOW_BASE = 2'd0;
    localparam logic [1:0] CFG_HOOK_PC_A   = 2'd1;
    localparam logic [1:0] CFG_HOOK_PC_B   = 2'd2;

    localparam logic [DATA_W-1:0] WINDOW_BASE_RST = 32'h8009_ba10;
    localparam logic [DATA_W-1:0] HOOK_PC_A_RST   = 32'h8004_33cc;
    localparam logic [DATA_W-1:0] HOOK_PC_B_RST   = 32'h8004_6764;

endpackage

### rtl/core/channel_bimap_snoop_table.sv
// Top level of the channel bimap snoop table.
// An accepted item is handled in two steps: in the accept cycle the two channel memories are
// read (one registered read port each); then, in ST_EXEC and once the output register is free or
// being emptied, the mapping is updated and the result is loaded into it; only then is a new item taken.
// The output register lets one finished result wait while the next item is accepted. Mapped
// state is held by a valid bit per entry, so both tables read as unmapped right after reset
// without any clearing pass. Configuration is written through cfg_we, cfg_index and cfg_data.
module channel_bimap_snoop_table
    import cbst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [DATA_W-1:0]   cfg_data,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [1:0]          mode,
    input  logic [DATA_W-1:0]   write_address,
    input  logic [DATA_W-1:0]   write_value,
    input  logic [DATA_W-1:0]   cpu_pc,
    input  logic [QUERY_W-1:0]  query_index,
    output logic                result_valid,
    input  logic                result_ready,
    output logic                write_taken,
    output logic                answer_valid,
    output logic [ANSWER_W-1:0] answer_channel
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                     state_reg, state_next;
    logic [DATA_W-1:0]        window_base_reg, hook_pc_a_reg, hook_pc_b_reg;

    logic [CHANNEL_COUNT-1:0] p2l_v_reg, p2l_v_next;
    logic [CHANNEL_COUNT-1:0] l2p_v_reg, l2p_v_next;
    logic [CHAN_W-1:0]        p2l_mem [CHANNEL_COUNT];
    logic [CHAN_W-1:0]        l2p_mem [CHANNEL_COUNT];
    logic [CHAN_W-1:0]        p2l_rd_reg, l2p_rd_reg;

    logic [1:0]               mode_reg;
    logic                     taken_reg;
    logic [CHAN_W-1:0]        phys_reg;
    logic [CHAN_W-1:0]        logc_reg;
    logic                     logc_ok_reg;
    logic [CHAN_W-1:0]        q_reg;
    logic                     q_ok_reg;

    logic                     result_valid_reg, result_valid_next;
    logic                     write_taken_reg;
    logic                     answer_valid_reg;
    logic [ANSWER_W-1:0]      answer_channel_reg;

    logic                     accept;
    logic                     exec_fire;
    logic [DATA_W-1:0]        offset;
    logic                     in_window;
    logic                     hook_hit;
    logic [DATA_W-1:0]        logc_full;
    logic                     logc_ok;
    logic                     q_ok;
    logic [CHAN_W-1:0]        phys;
    logic [CHAN_W-1:0]        logc;
    logic                     p2l_re, l2p_re;
    logic [CHAN_W-1:0]        p2l_ra, l2p_ra;

    logic                     old_ok;
    logic                     oldp_ok;
    logic                     ans_valid;
    logic [CHAN_W-1:0]        ans_chan;

    assign item_ready     = (state_reg == ST_IDLE);
    assign accept         = item_valid && item_ready;
    assign exec_fire      = (state_reg == ST_EXEC) && (!result_valid_reg || result_ready);

    assign result_valid   = result_valid_reg;
    assign write_taken    = write_taken_reg;
    assign answer_valid   = answer_valid_reg;
    assign answer_channel = answer_channel_reg;

    // Decode of the incoming item and memory read addresses.
    assign offset    = write_address - window_base_reg;
    assign in_window = offset < DATA_W'(2 * CHANNEL_COUNT);
    assign hook_hit  = (cpu_pc == hook_pc_a_reg) || (cpu_pc == hook_pc_b_reg);
    assign logc_full = write_value - DATA_W'(1);
    assign logc_ok   = logc_full < DATA_W'(CHANNEL_COUNT);
    assign q_ok      = query_index < QUERY_W'(CHANNEL_COUNT);
    assign phys      = offset[CHAN_W:1];
    assign logc      = logc_full[CHAN_W-1:0];

    always_comb
    begin
        p2l_re = 1'b0;
        l2p_re = 1'b0;
        p2l_ra = phys;
        l2p_ra = logc;
        case (mode)
            MODE_WRITE:
            begin
                p2l_re = accept && in_window;
                l2p_re = accept && logc_ok;
            end
            MODE_P2L:
            begin
                p2l_ra = query_index[CHAN_W-1:0];
                p2l_re = accept && q_ok;
            end
            MODE_L2P:
            begin
                l2p_ra = query_index[CHAN_W-1:0];
                l2p_re = accept && q_ok;
            end
            default:
            begin
                p2l_re = 1'b0;
                l2p_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (p2l_re)
        begin
            p2l_rd_reg <= p2l_mem[p2l_ra];
        end
        if (exec_fire && taken_reg && logc_ok_reg)
        begin
            p2l_mem[phys_reg] <= logc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (l2p_re)
        begin
            l2p_rd_reg <= l2p_mem[l2p_ra];
        end
        if (exec_fire && taken_reg && logc_ok_reg)
        begin
            l2p_mem[logc_reg] <= phys_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg    <= mode;
            taken_reg   <= (mode == MODE_WRITE) && in_window && hook_hit;
            phys_reg    <= phys;
            logc_reg    <= logc;
            logc_ok_reg <= logc_ok;
            q_reg       <= query_index[CHAN_W-1:0];
            q_ok_reg    <= q_ok;
        end
        if (exec_fire)
        begin
            write_taken_reg    <= taken_reg;
            answer_valid_reg   <= ans_valid;
            answer_channel_reg <= ANSWER_W'(ans_chan);
        end
    end

    // The stale reverse entry is cleared first; when it is the entry about to be remapped,
    // its second stale clear must not happen.
    always_comb
    begin
        old_ok     = p2l_v_reg[phys_reg];
        oldp_ok    = l2p_v_reg[logc_reg] && !(old_ok && (p2l_rd_reg == logc_reg));
        p2l_v_next = p2l_v_reg;
        l2p_v_next = l2p_v_reg;
        if (exec_fire && taken_reg)
        begin
            if (old_ok)
            begin
                l2p_v_next[p2l_rd_reg] = 1'b0;
            end
            if (logc_ok_reg)
            begin
                if (oldp_ok)
                begin
                    p2l_v_next[l2p_rd_reg] = 1'b0;
                end
                p2l_v_next[phys_reg] = 1'b1;
                l2p_v_next[logc_reg] = 1'b1;
            end
            else
            begin
                p2l_v_next[phys_reg] = 1'b0;
            end
        end
    end

    always_comb
    begin
        ans_valid = 1'b0;
        ans_chan  = '0;
        case (mode_reg)
            MODE_P2L:
            begin
                ans_valid = q_ok_reg && p2l_v_reg[q_reg];
                ans_chan  = ans_valid ? p2l_rd_reg : '0;
            end
            MODE_L2P:
            begin
                ans_valid = q_ok_reg && l2p_v_reg[q_reg];
                ans_chan  = ans_valid ? l2p_rd_reg : '0;
            end
            default:
            begin
                ans_valid = 1'b0;
                ans_chan  = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (exec_fire)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            p2l_v_reg        <= '0;
            l2p_v_reg        <= '0;
            window_base_reg  <= WINDOW_BASE_RST;
            hook_pc_a_reg    <= HOOK_PC_A_RST;
            hook_pc_b_reg    <= HOOK_PC_B_RST;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            p2l_v_reg        <= p2l_v_next;
            l2p_v_reg        <= l2p_v_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WINDOW_BASE: window_base_reg <= cfg_data;
                    CFG_HOOK_PC_A:   hook_pc_a_reg   <= cfg_data;
                    CFG_HOOK_PC_B:   hook_pc_b_reg   <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_bimap_balanced: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(p2l_v_reg) == $countones(l2p_v_reg))
        else $error("Mapped entry counts of the two tables differ.");

    a_one_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !item_ready)
        else $error("A new item was taken while the previous one is still in work.");

    a_unmapped_answer_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !answer_valid |-> answer_channel == '0)
        else $error("An unmapped answer carries a nonzero channel.");

    a_taken_excludes_answer: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(write_taken && answer_valid))
        else $error("A result reports both a taken write and a query answer.");
`endif

endmodule
